@@ src/frame_stamp_ring_blend_select_top_assert.svh @@
// Assertion macros shared by the frame stamp ring checker.
`ifndef FRAME_STAMP_RING_BLEND_SELECT_TOP_ASSERT_SVH
`define FRAME_STAMP_RING_BLEND_SELECT_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSRBS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSRBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/fsrbs_pkg.sv @@
// Types and constants shared by the frame stamp ring modules.
package fsrbs_pkg;

   localparam int TIME_W    = 48;
   localparam int PERIOD_W  = 20;
   localparam int SLOT_W    = 6;
   localparam int BLEND_W   = 10;
   localparam int CSR_IDX_W = 1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20000);
   localparam logic [PERIOD_W-1:0] JITTER_RESET = PERIOD_W'(15000);

   // The blend scale of 1000 is built as 1024 - 32 + 8.
   localparam int SCALE_SH_A = 10;
   localparam int SCALE_SH_B = 5;
   localparam int SCALE_SH_C = 3;

   localparam int NUM_W     = TIME_W + SCALE_SH_A;
   localparam int DIV_STEPS = BLEND_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic {
      OP_FRAME = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_PERIOD = 1'b0,
      CSR_JITTER_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      RSP_FRAME,
      RSP_DROP,
      RSP_BLEND_ZERO,
      RSP_BLEND
   } rsp_kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_NF_DIFF,
      S_NF_CHECK,
      S_NF_WRITE,
      S_Q_TEST,
      S_Q_CMP,
      S_Q_PREV,
      S_Q_SPAN,
      S_Q_CHECK,
      S_Q_MUL2,
      S_Q_DIV,
      S_Q_FIN
   } state_type;

   typedef struct packed {
      logic         capture;
      logic         nf_advance;
      logic         nf_diff;
      logic         nf_check;
      logic         nf_write;
      logic         q_setup;
      logic         rd_en;
      logic         rd_prev;
      logic         q_step;
      logic         latch_later;
      logic         q_span;
      logic         mul1;
      logic         mul2;
      logic         div_step;
      logic         load_rsp;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   cnt_zero;
      logic   stamp_gt;
      logic   drop;
      logic   span_zero;
      logic   div_last;
   } status_type;

endpackage

@@ src/fsrbs_ctrl.sv @@
// Sequencer for the frame stamp ring: request intake, walk, divide and result handoff.
module fsrbs_ctrl
   import fsrbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_START;
            end
         end
         S_START: begin
            if (status.op == OP_QUERY) begin
               cmd.q_setup = 1'b1;
               state_in    = S_Q_TEST;
            end else begin
               cmd.nf_advance = 1'b1;
               state_in       = S_NF_DIFF;
            end
         end
         S_NF_DIFF: begin
            cmd.nf_diff = 1'b1;
            state_in    = S_NF_CHECK;
         end
         S_NF_CHECK: begin
            cmd.nf_check = 1'b1;
            state_in     = S_NF_WRITE;
         end
         S_NF_WRITE: begin
            if (rsp_free) begin
               cmd.nf_write = 1'b1;
               cmd.load_rsp = 1'b1;
               cmd.rsp_kind = RSP_FRAME;
               state_in     = S_IDLE;
            end
         end
         S_Q_TEST: begin
            cmd.rd_en = 1'b1;
            if (status.cnt_zero) begin
               state_in = S_Q_PREV;
            end else begin
               state_in = S_Q_CMP;
            end
         end
         S_Q_CMP: begin
            if (status.stamp_gt) begin
               state_in = S_Q_PREV;
            end else begin
               cmd.q_step = 1'b1;
               state_in   = S_Q_TEST;
            end
         end
         S_Q_PREV: begin
            cmd.latch_later = 1'b1;
            cmd.rd_en       = 1'b1;
            cmd.rd_prev     = 1'b1;
            state_in        = S_Q_SPAN;
         end
         S_Q_SPAN: begin
            cmd.q_span = 1'b1;
            state_in   = S_Q_CHECK;
         end
         S_Q_CHECK: begin
            if (status.drop) begin
               if (rsp_free) begin
                  cmd.load_rsp = 1'b1;
                  cmd.rsp_kind = RSP_DROP;
                  state_in     = S_IDLE;
               end
            end else if (status.span_zero) begin
               if (rsp_free) begin
                  cmd.load_rsp = 1'b1;
                  cmd.rsp_kind = RSP_BLEND_ZERO;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.mul1 = 1'b1;
               state_in = S_Q_MUL2;
            end
         end
         S_Q_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_Q_DIV;
         end
         S_Q_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_Q_FIN;
            end
         end
         S_Q_FIN: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_kind = RSP_BLEND;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ src/fsrbs_datapath.sv @@
// Datapath of the frame stamp ring: stamp memory, ring pointers, walk, blend divider.
module fsrbs_datapath
   import fsrbs_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic                 req_operation,
   input  logic [TIME_W-1:0]    req_time_us,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PERIOD_W-1:0]  csr_wdata,
   output logic [SLOT_W-1:0]    rsp_written_slot,
   output logic [TIME_W-1:0]    rsp_stamp_us,
   output logic                 rsp_ring_full,
   output logic                 rsp_shown,
   output logic [SLOT_W-1:0]    rsp_from_slot,
   output logic [SLOT_W-1:0]    rsp_to_slot,
   output logic [BLEND_W-1:0]   rsp_blend
);

   localparam int SIDX_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
   localparam logic [SIDX_W-1:0] LAST_SLOT = SIDX_W'(SLOTS - 1);

   function automatic logic [SIDX_W-1:0] slot_next(input logic [SIDX_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [SIDX_W-1:0] slot_prev(input logic [SIDX_W-1:0] s);
      return (s == '0) ? LAST_SLOT : s - 1'b1;
   endfunction

   logic [PERIOD_W-1:0] period_ff, jitter_ff;
   logic [SIDX_W-1:0]   ws_ff, rs_ff, np_ff, cnt_ff, cnt_in, np2, rd_addr;
   logic [TIME_W-1:0]   rstamp_ff, t_ff, dt_ff, later_ff, el_ff, span_ff;
   logic [TIME_W-1:0]   rd_ff, stamp_rd;
   logic [TIME_W:0]     diff_ff;
   logic [TIME_W+1:0]   diff_ext, lim_ext, sum_ext;
   logic [SIDX_W:0]     ring_sum;
   logic [NUM_W-1:0]    n_ff, d_ff;
   logic [BLEND_W-1:0]  q_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                op_ff, rd_vld_ff, resync, div_ge, shown_kind;
   logic [SLOTS-1:0]    valid_ff;
   logic [TIME_W-1:0]   mem [SLOTS];

   assign np2      = slot_prev(np_ff);
   assign rd_addr  = cmd.rd_prev ? np2 : np_ff;
   assign stamp_rd = rd_vld_ff ? rd_ff : '0;

   assign ring_sum = (ws_ff >= rs_ff) ? ({1'b0, ws_ff} - {1'b0, rs_ff})
                                      : ({1'b0, ws_ff} + (SIDX_W + 1)'(SLOTS) - {1'b0, rs_ff});
   assign cnt_in   = ring_sum[SIDX_W-1:0];

   assign diff_ext = {diff_ff[TIME_W], diff_ff};
   assign lim_ext  = {{(TIME_W + 2 - PERIOD_W){1'b0}}, jitter_ff};
   assign sum_ext  = diff_ext + lim_ext;
   assign resync   = diff_ff[TIME_W] ? sum_ext[TIME_W+1]
                                     : (diff_ff[TIME_W-1:0] > TIME_W'(jitter_ff));

   assign div_ge   = (n_ff >= d_ff);

   always_comb begin
      shown_kind = 1'b0;
      unique case (cmd.rsp_kind) inside
         RSP_BLEND, RSP_BLEND_ZERO: shown_kind = 1'b1;
         default:                   shown_kind = 1'b0;
      endcase
   end

   assign status.op        = op_type'(op_ff);
   assign status.cnt_zero  = (cnt_ff == '0);
   assign status.stamp_gt  = (stamp_rd > dt_ff);
   assign status.drop      = (el_ff > span_ff);
   assign status.span_zero = (span_ff == '0);
   assign status.div_last  = (step_ff == STEP_W'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         jitter_ff <= JITTER_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_PERIOD: period_ff <= csr_wdata;
            CSR_JITTER_LIMIT: jitter_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff     <= '0;
         rs_ff     <= '0;
         rstamp_ff <= '0;
         valid_ff  <= '0;
      end else begin
         if (cmd.nf_advance) begin
            ws_ff     <= slot_next(ws_ff);
            rstamp_ff <= rstamp_ff + TIME_W'(period_ff);
         end
         if (cmd.nf_check && resync) begin
            rstamp_ff <= t_ff;
         end
         if (cmd.nf_write) begin
            valid_ff[ws_ff] <= 1'b1;
         end
         if (cmd.load_rsp && shown_kind) begin
            rs_ff <= np2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.nf_write) begin
         mem[ws_ff] <= rstamp_ff;
      end
      if (cmd.rd_en) begin
         rd_ff     <= mem[rd_addr];
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_operation;
         t_ff  <= req_time_us;
      end
      if (cmd.nf_diff) begin
         diff_ff <= {1'b0, t_ff} - {1'b0, rstamp_ff};
      end
      if (cmd.q_setup) begin
         dt_ff  <= t_ff - TIME_W'(period_ff);
         cnt_ff <= cnt_in;
         np_ff  <= rs_ff;
      end
      if (cmd.q_step) begin
         np_ff  <= slot_next(np_ff);
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.latch_later) begin
         later_ff <= stamp_rd;
      end
      if (cmd.q_span) begin
         el_ff   <= dt_ff - stamp_rd;
         span_ff <= later_ff - stamp_rd;
      end
      if (cmd.mul1) begin
         n_ff <= (NUM_W'(el_ff) << SCALE_SH_A) - (NUM_W'(el_ff) << SCALE_SH_B);
      end
      if (cmd.mul2) begin
         n_ff    <= n_ff + (NUM_W'(el_ff) << SCALE_SH_C);
         d_ff    <= NUM_W'(span_ff) << (DIV_STEPS - 1);
         q_ff    <= '0;
         step_ff <= '0;
      end
      if (cmd.div_step) begin
         if (div_ge) begin
            n_ff <= n_ff - d_ff;
         end
         q_ff    <= {q_ff[BLEND_W-2:0], div_ge};
         d_ff    <= d_ff >> 1;
         step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         unique case (cmd.rsp_kind)
            RSP_FRAME: begin
               rsp_written_slot <= SLOT_W'(ws_ff);
               rsp_stamp_us     <= rstamp_ff;
               rsp_ring_full    <= (ws_ff == rs_ff);
               rsp_shown        <= 1'b0;
               rsp_from_slot    <= '0;
               rsp_to_slot      <= '0;
               rsp_blend        <= '0;
            end
            RSP_BLEND_ZERO: begin
               rsp_written_slot <= '0;
               rsp_stamp_us     <= '0;
               rsp_ring_full    <= 1'b0;
               rsp_shown        <= 1'b1;
               rsp_from_slot    <= SLOT_W'(np2);
               rsp_to_slot      <= SLOT_W'(np_ff);
               rsp_blend        <= '0;
            end
            RSP_BLEND: begin
               rsp_written_slot <= '0;
               rsp_stamp_us     <= '0;
               rsp_ring_full    <= 1'b0;
               rsp_shown        <= 1'b1;
               rsp_from_slot    <= SLOT_W'(np2);
               rsp_to_slot      <= SLOT_W'(np_ff);
               rsp_blend        <= q_ff;
            end
            default: begin
               rsp_written_slot <= '0;
               rsp_stamp_us     <= '0;
               rsp_ring_full    <= 1'b0;
               rsp_shown        <= 1'b0;
               rsp_from_slot    <= '0;
               rsp_to_slot      <= '0;
               rsp_blend        <= '0;
            end
         endcase
      end
   end

endmodule

@@ src/frame_stamp_ring_blend_select_top.sv @@
// Top level of the frame stamp ring with blend selection.
//
// A request carries an operation and a 48-bit time. A new-frame request
// stamps the next ring slot and returns the slot, its stamp and a ring-full
// flag. A display request returns the slot pair around its time minus one
// frame period and a blend weight in thousandths, or a drop.
// Each request gives exactly one response on the rsp channel.
// One request is in work at a time. A display response is a drop, an
// empty span, or a blend weight that the ten-step restoring divider forms
// after a ring walk compares at most SLOTS-1 slot stamps. The next request
// is accepted in the cycle after the response is loaded.
// The response sits in an output register, so a new request is accepted
// while a finished response still waits; when the receiver stalls, the
// block finishes its next request and holds it until the register frees.
// Reset clears the ring pointers, the running stamp and all slot valid
// flags, and loads the default period and jitter limit. The csr port
// writes the period or the jitter limit; the user must write them only
// while the block is idle, and the block itself does not enforce this.
module frame_stamp_ring_blend_select_top
   import fsrbs_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [TIME_W-1:0]    req_time_us,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SLOT_W-1:0]    rsp_written_slot,
   output logic [TIME_W-1:0]    rsp_stamp_us,
   output logic                 rsp_ring_full,
   output logic                 rsp_shown,
   output logic [SLOT_W-1:0]    rsp_from_slot,
   output logic [SLOT_W-1:0]    rsp_to_slot,
   output logic [BLEND_W-1:0]   rsp_blend,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PERIOD_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   fsrbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fsrbs_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_time_us      (req_time_us),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_written_slot (rsp_written_slot),
      .rsp_stamp_us     (rsp_stamp_us),
      .rsp_ring_full    (rsp_ring_full),
      .rsp_shown        (rsp_shown),
      .rsp_from_slot    (rsp_from_slot),
      .rsp_to_slot      (rsp_to_slot),
      .rsp_blend        (rsp_blend)
   );

endmodule

@@ src/fsrbs_checker.sv @@
// Port-level checker for the frame stamp ring, bound to the top level.
`include "frame_stamp_ring_blend_select_top_assert.svh"

module fsrbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [5:0]  rsp_written_slot,
   input logic [47:0] rsp_stamp_us,
   input logic        rsp_ring_full,
   input logic        rsp_shown,
   input logic [5:0]  rsp_from_slot,
   input logic [5:0]  rsp_to_slot,
   input logic [9:0]  rsp_blend
);

   `FSRBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_stamp_us) && $stable(rsp_blend) && $stable(rsp_shown), "Stalled response changed.")

   `FSRBS_ASSERT_NEXT(a_one_request, req_valid && !req_stall, req_stall, "Request accepted while another is in work.")

   `FSRBS_ASSERT_SAME(a_shown_fields, rsp_valid && rsp_shown, rsp_written_slot == 6'd0 && rsp_stamp_us == 48'd0 && !rsp_ring_full && rsp_blend <= 10'd1000, "Displayed response has bad fields.")

   `FSRBS_ASSERT_SAME(a_unshown_fields, rsp_valid && !rsp_shown, rsp_from_slot == 6'd0 && rsp_to_slot == 6'd0 && rsp_blend == 10'd0, "Frame or drop response has pair fields set.")

endmodule

bind frame_stamp_ring_blend_select_top fsrbs_checker u_fsrbs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_written_slot (rsp_written_slot),
   .rsp_stamp_us     (rsp_stamp_us),
   .rsp_ring_full    (rsp_ring_full),
   .rsp_shown        (rsp_shown),
   .rsp_from_slot    (rsp_from_slot),
   .rsp_to_slot      (rsp_to_slot),
   .rsp_blend        (rsp_blend)
);

@@ tb/sv/frame_stamp_ring_blend_select_top_tb.sv @@
// Testbench for the frame stamp ring with blend selection: directed and random traffic checked against a predictor.
module frame_stamp_ring_blend_select_top_tb
   import fsrbs_pkg::*;
();

   localparam int NSLOTS = 8;
   localparam int PHASE_ITEMS = 265;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PRINT_CAP = 60;

   typedef enum {IDLE_NONE, IDLE_HEAVY, IDLE_SPARSE} idle_mode_type;

   typedef struct packed {
      op_type              op;
      logic [TIME_W-1:0]   time_us;
   } frame_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   written_slot;
      logic [TIME_W-1:0]   stamp_us;
      logic                ring_full;
      logic                shown;
      logic [SLOT_W-1:0]   from_slot;
      logic [SLOT_W-1:0]   to_slot;
      logic [BLEND_W-1:0]  blend;
   } frame_rsp_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_operation = 1'b0;
   logic [TIME_W-1:0]    req_time_us = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [SLOT_W-1:0]    rsp_written_slot;
   logic [TIME_W-1:0]    rsp_stamp_us;
   logic                 rsp_ring_full;
   logic                 rsp_shown;
   logic [SLOT_W-1:0]    rsp_from_slot;
   logic [SLOT_W-1:0]    rsp_to_slot;
   logic [BLEND_W-1:0]   rsp_blend;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [PERIOD_W-1:0]  csr_wdata = '0;

   frame_req_type queued_reqs[$];
   frame_rsp_type owed_rsps[$];

   logic [TIME_W-1:0]   ring_stamps [NSLOTS];
   int unsigned         wr_slot = 0;
   int unsigned         rd_slot = 0;
   logic [TIME_W-1:0]   run_stamp = '0;
   logic [PERIOD_W-1:0] cfg_period = PERIOD_RESET;
   logic [PERIOD_W-1:0] cfg_jitter = JITTER_RESET;

   logic [TIME_W-1:0]   stim_now = '0;
   idle_mode_type       req_idle = IDLE_SPARSE;
   idle_mode_type       rsp_idle = IDLE_SPARSE;
   bit                  req_taken = 1'b0;
   bit                  rsp_taken = 1'b0;
   int unsigned         req_gap = 0;
   int unsigned         rsp_hold = 0;
   int unsigned         quiet_cycles = 0;
   int unsigned         fail_count = 0;

   frame_stamp_ring_blend_select_top #(
      .SLOTS(NSLOTS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_time_us      (req_time_us),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_written_slot (rsp_written_slot),
      .rsp_stamp_us     (rsp_stamp_us),
      .rsp_ring_full    (rsp_ring_full),
      .rsp_shown        (rsp_shown),
      .rsp_from_slot    (rsp_from_slot),
      .rsp_to_slot      (rsp_to_slot),
      .rsp_blend        (rsp_blend),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic frame_rsp_type ring_answer(input op_type op, input logic [TIME_W-1:0] t);
      frame_rsp_type      r;
      logic signed [49:0] drift;
      logic signed [49:0] lim;
      logic [TIME_W-1:0]  dt;
      logic [TIME_W-1:0]  elapsed;
      logic [TIME_W-1:0]  span;
      logic [63:0]        prod;
      int unsigned        visits;
      int unsigned        later;
      int unsigned        earlier;
      bit                 found;
      r = '0;
      if (op == OP_FRAME) begin
         wr_slot = (wr_slot + 1) % NSLOTS;
         run_stamp = run_stamp + TIME_W'(cfg_period);
         drift = $signed({2'b00, t}) - $signed({2'b00, run_stamp});
         lim = $signed({30'd0, cfg_jitter});
         if (drift > lim || drift < -lim) begin
            run_stamp = t;
         end
         ring_stamps[wr_slot] = run_stamp;
         r.written_slot = SLOT_W'(wr_slot);
         r.stamp_us = run_stamp;
         r.ring_full = (wr_slot == rd_slot);
      end else begin
         dt = t - TIME_W'(cfg_period);
         visits = (wr_slot + NSLOTS - rd_slot) % NSLOTS;
         later = rd_slot;
         found = 1'b0;
         for (int i = 0; i < visits; i++) begin
            if (!found) begin
               if (ring_stamps[later] > dt) begin
                  found = 1'b1;
               end else begin
                  later = (later + 1) % NSLOTS;
               end
            end
         end
         earlier = (later == 0) ? NSLOTS - 1 : later - 1;
         elapsed = dt - ring_stamps[earlier];
         span = ring_stamps[later] - ring_stamps[earlier];
         if (elapsed <= span) begin
            r.shown = 1'b1;
            r.from_slot = SLOT_W'(earlier);
            r.to_slot = SLOT_W'(later);
            prod = 64'(elapsed) * 64'd1000;
            r.blend = (span == '0) ? '0 : BLEND_W'(prod / 64'(span));
            rd_slot = earlier;
         end
      end
      return r;
   endfunction

   function automatic int unsigned draw_wait(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: return 0;
         IDLE_HEAVY: return $urandom_range(0, 16);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (fail_count < PRINT_CAP) begin
         $display("MISMATCH %s: got %0h, want %0h", what, got, want);
      end
      fail_count++;
   endtask

   // Request driver.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         frame_req_type nxt;
         if (req_taken) begin
            req_gap = draw_wait(req_idle);
         end
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (queued_reqs.size() > 0) begin
            nxt = queued_reqs.pop_front();
            req_valid <= 1'b1;
            req_operation <= nxt.op;
            req_time_us <= nxt.time_us;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response receiver.
   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_hold = draw_wait(rsp_idle);
      end
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor, predictor and watchdog.
   always @(posedge clock) begin : monitor
      frame_rsp_type want;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            if (owed_rsps.size() == 0) begin
               report_mismatch("response with no request owed", 64'(rsp_stamp_us), 64'd0);
            end else begin
               want = owed_rsps.pop_front();
               if (rsp_written_slot !== want.written_slot)
                  report_mismatch("written_slot", 64'(rsp_written_slot), 64'(want.written_slot));
               if (rsp_stamp_us !== want.stamp_us)
                  report_mismatch("stamp_us", 64'(rsp_stamp_us), 64'(want.stamp_us));
               if (rsp_ring_full !== want.ring_full)
                  report_mismatch("ring_full", 64'(rsp_ring_full), 64'(want.ring_full));
               if (rsp_shown !== want.shown)
                  report_mismatch("shown", 64'(rsp_shown), 64'(want.shown));
               if (rsp_from_slot !== want.from_slot)
                  report_mismatch("from_slot", 64'(rsp_from_slot), 64'(want.from_slot));
               if (rsp_to_slot !== want.to_slot)
                  report_mismatch("to_slot", 64'(rsp_to_slot), 64'(want.to_slot));
               if (rsp_blend !== want.blend)
                  report_mismatch("blend", 64'(rsp_blend), 64'(want.blend));
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            owed_rsps.push_back(ring_answer(op_type'(req_operation), req_time_us));
         end
         if (req_taken || rsp_taken ||
             (queued_reqs.size() == 0 && !req_valid && owed_rsps.size() == 0)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic queue_item(input op_type op, input logic [TIME_W-1:0] t);
      frame_req_type item;
      item.op = op;
      item.time_us = t;
      queued_reqs.push_back(item);
   endtask

   task automatic set_timing(input logic [PERIOD_W-1:0] period,
                             input logic [PERIOD_W-1:0] jitter);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_FRAME_PERIOD;
      csr_wdata <= period;
      @(negedge clock);
      csr_index <= CSR_JITTER_LIMIT;
      csr_wdata <= jitter;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_period = period;
      cfg_jitter = jitter;
   endtask

   task automatic wait_idle();
      while (queued_reqs.size() != 0 || req_valid || owed_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // New frame near the ideal cadence, with drift inside or beyond the jitter limit.
   task automatic add_frame();
      int unsigned       pick;
      int unsigned       off;
      logic [TIME_W-1:0] t;
      stim_now = stim_now + TIME_W'(cfg_period);
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         stim_now = stim_now + TIME_W'({$urandom, $urandom});
      end
      if (pick < 12) begin
         off = $urandom_range(0, int'(cfg_jitter));
      end else begin
         off = int'(cfg_jitter) + $urandom_range(1, 5000);
      end
      t = $urandom_range(0, 1) ? stim_now + TIME_W'(off) : stim_now - TIME_W'(off);
      queue_item(OP_FRAME, t);
   endtask

   // Display query whose time minus one period lands among the recent frames.
   task automatic add_query();
      int unsigned       off;
      logic [TIME_W-1:0] t;
      off = $urandom_range(0, 3 * int'(cfg_period) + 16);
      if ($urandom_range(0, 7) == 0) begin
         t = stim_now + TIME_W'(cfg_period) + TIME_W'(off);
      end else begin
         t = stim_now + TIME_W'(cfg_period) - TIME_W'(off);
      end
      queue_item(OP_QUERY, t);
   endtask

   task automatic add_traffic(input int count);
      int made;
      int run_len;
      int query_share;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 7) == 0) begin
            queue_item(op_type'($urandom_range(0, 1)), TIME_W'({$urandom, $urandom}));
            made++;
         end else begin
            run_len = $urandom_range(4, 24);
            query_share = $urandom_range(1, 3);
            for (int k = 0; k < run_len; k++) begin
               if ($urandom_range(0, 3) < query_share) begin
                  add_query();
               end else begin
                  add_frame();
               end
               made++;
            end
         end
      end
   endtask

   task automatic run_phase(input logic [PERIOD_W-1:0] period,
                            input logic [PERIOD_W-1:0] jitter,
                            input idle_mode_type req_mode, input idle_mode_type rsp_mode);
      set_timing(period, jitter);
      req_idle = req_mode;
      rsp_idle = rsp_mode;
      add_traffic(PHASE_ITEMS);
      wait_idle();
   endtask

   initial begin
      for (int i = 0; i < NSLOTS; i++) begin
         ring_stamps[i] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset timing.
      queue_item(OP_QUERY, '0);
      queue_item(OP_QUERY, TIME_W'(20000));
      queue_item(OP_FRAME, TIME_W'(20000));
      queue_item(OP_FRAME, TIME_W'(55000));
      queue_item(OP_FRAME, TIME_W'(44999));
      queue_item(OP_QUERY, TIME_W'(50000));
      queue_item(OP_QUERY, TIME_W'(64999));
      queue_item(OP_QUERY, TIME_W'(10000000));
      queue_item(OP_FRAME, '1);
      queue_item(OP_FRAME, '0);
      queue_item(OP_QUERY, '1);
      queue_item(OP_QUERY, TIME_W'(20000));
      for (int k = 1; k <= 9; k++) begin
         queue_item(OP_FRAME, TIME_W'(20000 * k));
      end
      queue_item(OP_QUERY, TIME_W'(90000));
      queue_item(OP_QUERY, TIME_W'(130000));
      queue_item(OP_FRAME, 48'h5555_5555_5555);
      queue_item(OP_QUERY, 48'hAAAA_AAAA_AAAA);
      wait_idle();

      run_phase(PERIOD_W'(1), PERIOD_W'(0), IDLE_HEAVY, IDLE_SPARSE);
      stim_now = 48'hFFFF_FFF0_0000;
      run_phase(PERIOD_W'(1000000), PERIOD_W'(1000000), IDLE_NONE, IDLE_NONE);
      run_phase(PERIOD_W'(0), PERIOD_W'(0), IDLE_SPARSE, IDLE_HEAVY);
      run_phase(PERIOD_W'(16667), PERIOD_W'(2000), IDLE_HEAVY, IDLE_HEAVY);
      run_phase(PERIOD_W'($urandom_range(1, 1000000)), PERIOD_W'($urandom_range(0, 1000000)),
                IDLE_SPARSE, IDLE_NONE);
      run_phase(PERIOD_W'($urandom_range(1, 1000000)), PERIOD_W'($urandom_range(0, 1000000)),
                IDLE_NONE, IDLE_HEAVY);
      run_phase(PERIOD_W'($urandom_range(1, 100000)), PERIOD_W'($urandom_range(0, 100000)),
                IDLE_SPARSE, IDLE_SPARSE);

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/fsrbs_pkg.sv
src/fsrbs_ctrl.sv
src/fsrbs_datapath.sv
src/frame_stamp_ring_blend_select_top.sv
src/fsrbs_checker.sv
tb/sv/frame_stamp_ring_blend_select_top_tb.sv
